// ===== hdl/vcrr_pkg.sv =====
`timescale 1ns / 1ps

package vcrr_pkg;

    localparam int NUM_VC    = 4;
    localparam int VC_W      = (NUM_VC > 1) ? $clog2(NUM_VC) : 1;

    localparam int ACTION_W  = 2;
    localparam int PORT_W    = 2;
    localparam int MSG_W     = 32;
    localparam int DSTOP_W   = 4;
    localparam int SCH_W     = 2;
    localparam int ISTOP_W   = 4;

    localparam int IN_TDATA_W  = ((PORT_W + MSG_W + DSTOP_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = ACTION_W;
    localparam int OUT_TDATA_W = ((SCH_W + MSG_W + ISTOP_W + 1 + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ARRIVE    = 2'd0,
        ACT_STOP_RISE = 2'd1,
        ACT_ARBITRATE = 2'd2,
        ACT_SEND      = 2'd3
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [PORT_W-1:0]    port;
        logic [MSG_W-1:0]     payload;
        logic [DSTOP_W-1:0]   downstream_stop;
    } t_item;

    typedef struct packed {
        logic                 send_valid;
        logic [SCH_W-1:0]     send_channel;
        logic [MSG_W-1:0]     send_payload;
        logic [ISTOP_W-1:0]   input_stop;
        logic                 grant_valid;
    } t_result;

    typedef struct packed {
        logic                 found;
        logic [VC_W-1:0]      channel;
    } t_scan;

endpackage

// ===== hdl/vc_round_robin_multiplexer.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | tdata (low bit up)                                 | tuser
// s        | in  | port[1:0] payload[33:2] downstream_stop[37:34]     | action[1:0]
// m        | out | send_channel[1:0] send_payload[33:2]               | send_valid
//          |     |   input_stop[37:34] grant_valid[38]                |
//
// One transaction per cycle while the output is not stalled; the result passes
// the input register, then the state update and scan into the output register,
// before it is offered. The round-robin scan in the state update is combinational.
// Synchronous active-low reset clears slots' full bits, grant, pointer, stops.
// A stalled output holds; the input register still drains when the output frees.
module vc_round_robin_multiplexer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [vcrr_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // port, payload, downstream_stop
    input  logic [vcrr_pkg::IN_TUSER_W-1:0]  i_s_tuser,  // action

    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [vcrr_pkg::OUT_TDATA_W-1:0] o_m_tdata,  // send_channel, send_payload,
                                                         // input_stop, grant_valid
    output logic [vcrr_pkg::OUT_TUSER_W-1:0] o_m_tuser   // send_valid
);

    logic              r_in_valid;
    vcrr_pkg::t_item   r_in;
    logic              r_out_valid;
    vcrr_pkg::t_result r_out;

    vcrr_pkg::t_item   in_item;
    vcrr_pkg::t_result result;
    logic              step;

    assign in_item.action          = vcrr_pkg::t_action'(i_s_tuser);
    assign in_item.port            = i_s_tdata[vcrr_pkg::PORT_W-1:0];
    assign in_item.payload         = i_s_tdata[vcrr_pkg::PORT_W +: vcrr_pkg::MSG_W];
    assign in_item.downstream_stop =
        i_s_tdata[vcrr_pkg::PORT_W + vcrr_pkg::MSG_W +: vcrr_pkg::DSTOP_W];

    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;

    vcrr_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= in_item;
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.send_valid;
    assign o_m_tdata  = vcrr_pkg::OUT_TDATA_W'({r_out.grant_valid, r_out.input_stop,
                                                r_out.send_payload, r_out.send_channel});

endmodule

// ===== hdl/vcrr_scan.sv =====
`timescale 1ns / 1ps

// round-robin priority scan: first eligible channel at or after the pointer
module vcrr_scan (
    input  logic [vcrr_pkg::NUM_VC-1:0] i_eligible,
    input  logic [vcrr_pkg::VC_W-1:0]   i_pointer,
    output vcrr_pkg::t_scan             o_scan
);

    logic [vcrr_pkg::VC_W:0] idx [vcrr_pkg::NUM_VC];

    always_comb begin
        for (int i = 0; i < vcrr_pkg::NUM_VC; i++) begin
            idx[i] = {1'b0, i_pointer} + (vcrr_pkg::VC_W + 1)'(i);
            if (idx[i] >= (vcrr_pkg::VC_W + 1)'(vcrr_pkg::NUM_VC)) begin
                idx[i] = idx[i] - (vcrr_pkg::VC_W + 1)'(vcrr_pkg::NUM_VC);
            end
        end
    end

    always_comb begin
        o_scan.found   = 1'b0;
        o_scan.channel = i_pointer;
        for (int i = 0; i < vcrr_pkg::NUM_VC; i++) begin
            if (!o_scan.found && i_eligible[idx[i][vcrr_pkg::VC_W-1:0]]) begin
                o_scan.found   = 1'b1;
                o_scan.channel = idx[i][vcrr_pkg::VC_W-1:0];
            end
        end
    end

endmodule

// ===== hdl/vcrr_state.sv =====
`timescale 1ns / 1ps

// channel slots, grant, pointer and stop bits; applies one transaction per step
module vcrr_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  vcrr_pkg::t_item   i_item,
    output vcrr_pkg::t_result o_result
);

    logic [vcrr_pkg::MSG_W-1:0]  r_msg [vcrr_pkg::NUM_VC];
    logic [vcrr_pkg::NUM_VC-1:0] r_full, n_full;
    logic [vcrr_pkg::NUM_VC-1:0] r_stop, n_stop;
    logic [vcrr_pkg::VC_W-1:0]   r_ptr, n_ptr;
    logic [vcrr_pkg::VC_W-1:0]   r_gch, n_gch;
    logic                        r_granted, n_granted;

    logic                        port_ok;
    logic [vcrr_pkg::VC_W-1:0]   port_idx;
    logic [vcrr_pkg::NUM_VC-1:0] eligible;
    logic [vcrr_pkg::NUM_VC-1:0] grant_mask;
    logic [vcrr_pkg::VC_W-1:0]   ptr_inc;
    logic                        send_hit;
    vcrr_pkg::t_scan             scan;

    assign port_ok  = 32'(i_item.port) < 32'(vcrr_pkg::NUM_VC);
    assign port_idx = vcrr_pkg::VC_W'(i_item.port);
    assign eligible = r_full & ~vcrr_pkg::NUM_VC'(i_item.downstream_stop);
    assign ptr_inc  = (r_ptr == vcrr_pkg::VC_W'(vcrr_pkg::NUM_VC - 1)) ? '0 : r_ptr + 1'b1;
    assign send_hit = (i_item.action == vcrr_pkg::ACT_SEND) && r_granted;

    vcrr_scan u_scan (
        .i_eligible (eligible),
        .i_pointer  (r_ptr),
        .o_scan     (scan)
    );

    assign grant_mask = scan.found ? (vcrr_pkg::NUM_VC'(1) << scan.channel) : '0;

    always_comb begin
        n_full    = r_full;
        n_stop    = r_stop;
        n_ptr     = r_ptr;
        n_gch     = r_gch;
        n_granted = r_granted;
        case (i_item.action)
            vcrr_pkg::ACT_ARRIVE: begin
                if (port_ok) begin
                    n_full[port_idx] = 1'b1;
                end
            end
            vcrr_pkg::ACT_STOP_RISE: begin
                if (port_ok && r_granted && (r_gch == port_idx)) begin
                    n_stop[port_idx] = 1'b1;
                    n_granted        = 1'b0;
                end
            end
            vcrr_pkg::ACT_ARBITRATE: begin
                n_granted = scan.found;
                if (scan.found) begin
                    n_gch = scan.channel;
                    n_ptr = scan.channel;
                end
                n_stop = r_full & ~grant_mask;
            end
            vcrr_pkg::ACT_SEND: begin
                if (r_granted) begin
                    n_full[r_gch] = 1'b0;
                    n_granted     = 1'b0;
                    n_ptr         = ptr_inc;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.send_valid   = send_hit;
        o_result.send_channel = send_hit ? vcrr_pkg::SCH_W'(r_gch) : '0;
        o_result.send_payload = send_hit ? r_msg[r_gch] : '0;
        o_result.input_stop   = vcrr_pkg::ISTOP_W'(n_stop);
        o_result.grant_valid  = n_granted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full    <= '0;
            r_stop    <= '0;
            r_ptr     <= '0;
            r_gch     <= '0;
            r_granted <= 1'b0;
        end else if (i_step) begin
            r_full    <= n_full;
            r_stop    <= n_stop;
            r_ptr     <= n_ptr;
            r_gch     <= n_gch;
            r_granted <= n_granted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && (i_item.action == vcrr_pkg::ACT_ARRIVE) && port_ok) begin
            r_msg[port_idx] <= i_item.payload;
        end
    end

    a_grant_on_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_granted |-> r_full[r_gch])
        else $error("grant held on an empty slot");

    a_grant_not_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_granted |-> !r_stop[r_gch])
        else $error("granted input is stopped");

    a_send_drops_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && send_hit) |=> !r_granted)
        else $error("grant survives a send");

    a_send_advances_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && send_hit) |=> (r_ptr == $past(ptr_inc)))
        else $error("pointer not advanced after send");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS = 1430;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct {
        vcrr_pkg::t_item   item;
        bit                known;
        vcrr_pkg::t_result want;
    } t_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    logic [vcrr_pkg::IN_TDATA_W-1:0]  i_s_tdata;   // port, payload, downstream_stop
    logic [vcrr_pkg::IN_TUSER_W-1:0]  i_s_tuser;   // action
    logic                             o_m_tvalid;
    logic                             i_m_tready;
    logic [vcrr_pkg::OUT_TDATA_W-1:0] o_m_tdata;   // send_channel, send_payload,
                                                   // input_stop, grant_valid
    logic [vcrr_pkg::OUT_TUSER_W-1:0] o_m_tuser;   // send_valid

    // shadow of the multiplexer state
    logic [vcrr_pkg::MSG_W-1:0]  slot_msg [vcrr_pkg::NUM_VC];
    logic [vcrr_pkg::NUM_VC-1:0] slot_busy;
    logic [vcrr_pkg::VC_W-1:0]   rr_ptr;
    logic                        grant_on;
    logic [vcrr_pkg::VC_W-1:0]   grant_ch;
    logic [vcrr_pkg::NUM_VC-1:0] in_stop;

    t_row              offered_q[$];
    t_row              dir_rows[$];
    vcrr_pkg::t_result pending_q[$];
    int                mismatch_cnt;
    int                burst_left;
    bit                stall_req;

    vc_round_robin_multiplexer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic vcrr_pkg::t_result vc_mux_step(vcrr_pkg::t_item it);
        vcrr_pkg::t_result r;
        bit                found;
        r = '0;
        case (it.action)
            vcrr_pkg::ACT_ARRIVE: begin
                slot_msg[it.port]  = it.payload;
                slot_busy[it.port] = 1'b1;
            end
            vcrr_pkg::ACT_STOP_RISE: begin
                if (grant_on && grant_ch == it.port) begin
                    in_stop[it.port] = 1'b1;
                    grant_on         = 1'b0;
                end
            end
            vcrr_pkg::ACT_ARBITRATE: begin
                found = 1'b0;
                for (int i = 0; i < vcrr_pkg::NUM_VC; i++) begin
                    if (!found) begin
                        if (slot_busy[rr_ptr] && !it.downstream_stop[rr_ptr]) begin
                            found    = 1'b1;
                            grant_ch = rr_ptr;
                        end else begin
                            rr_ptr = (rr_ptr == vcrr_pkg::NUM_VC - 1) ? '0 : rr_ptr + 1'b1;
                        end
                    end
                end
                grant_on = found;
                for (int c = 0; c < vcrr_pkg::NUM_VC; c++)
                    in_stop[c] = slot_busy[c] && !(found && grant_ch == c);
            end
            vcrr_pkg::ACT_SEND: begin
                if (grant_on) begin
                    r.send_valid        = 1'b1;
                    r.send_channel      = grant_ch;
                    r.send_payload      = slot_msg[grant_ch];
                    slot_busy[grant_ch] = 1'b0;
                    grant_on            = 1'b0;
                    rr_ptr = (rr_ptr == vcrr_pkg::NUM_VC - 1) ? '0 : rr_ptr + 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.input_stop  = in_stop;
        r.grant_valid = grant_on;
        return r;
    endfunction

    function automatic vcrr_pkg::t_item rand_item(vcrr_pkg::t_action a);
        vcrr_pkg::t_item it;
        it.action          = a;
        it.port            = vcrr_pkg::PORT_W'($urandom_range(0, 3));
        it.payload         = $urandom;
        it.downstream_stop = vcrr_pkg::DSTOP_W'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic add_row(vcrr_pkg::t_action a, logic [vcrr_pkg::PORT_W-1:0] port,
                           logic [vcrr_pkg::MSG_W-1:0] payload,
                           logic [vcrr_pkg::DSTOP_W-1:0] dstop, bit known,
                           vcrr_pkg::t_result want);
        t_row row;
        row.item.action          = a;
        row.item.port            = port;
        row.item.payload         = payload;
        row.item.downstream_stop = dstop;
        row.known                = known;
        row.want                 = want;
        dir_rows.push_back(row);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer(t_row row);
        logic [vcrr_pkg::IN_TDATA_W-1:0] d;
        int                              gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        d = '0;
        d[vcrr_pkg::PORT_W-1:0]                                  = row.item.port;
        d[vcrr_pkg::PORT_W +: vcrr_pkg::MSG_W]                   = row.item.payload;
        d[vcrr_pkg::PORT_W + vcrr_pkg::MSG_W +: vcrr_pkg::DSTOP_W] =
            row.item.downstream_stop;
        offered_q.push_back(row);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= row.item.action;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic offer_item(vcrr_pkg::t_item it);
        t_row row;
        row.item  = it;
        row.known = 1'b0;
        row.want  = '0;
        offer(row);
    endtask

    task automatic note_mismatch(string what, vcrr_pkg::t_result want,
                                 vcrr_pkg::t_result got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display({"%0t %s: exp sv=%0b ch=%0d pl=%h stop=%b gv=%0b, ",
                      "got sv=%0b ch=%0d pl=%h stop=%b gv=%0b"},
                     $time, what, want.send_valid, want.send_channel, want.send_payload,
                     want.input_stop, want.grant_valid, got.send_valid, got.send_channel,
                     got.send_payload, got.input_stop, got.grant_valid);
    endtask

    always @(posedge i_clk) begin : monitor
        t_row              row;
        vcrr_pkg::t_result r;
        vcrr_pkg::t_result got;
        vcrr_pkg::t_result want;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            row = offered_q.pop_front();
            r   = vc_mux_step(row.item);
            pending_q.push_back(row.known ? row.want : r);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.send_valid   = o_m_tuser[0];
            got.send_channel = o_m_tdata[vcrr_pkg::SCH_W-1:0];
            got.send_payload = o_m_tdata[vcrr_pkg::SCH_W +: vcrr_pkg::MSG_W];
            got.input_stop   =
                o_m_tdata[vcrr_pkg::SCH_W + vcrr_pkg::MSG_W +: vcrr_pkg::ISTOP_W];
            got.grant_valid  =
                o_m_tdata[vcrr_pkg::SCH_W + vcrr_pkg::MSG_W + vcrr_pkg::ISTOP_W];
            if (pending_q.size() == 0) begin
                note_mismatch("unexpected transaction", '0, got);
            end else begin
                want = pending_q.pop_front();
                if (got.send_valid !== want.send_valid || got.send_channel !== want.send_channel
                    || got.send_payload !== want.send_payload
                    || got.input_stop !== want.input_stop
                    || got.grant_valid !== want.grant_valid)
                    note_mismatch("mismatch", want, got);
            end
        end
    end

    initial begin : receiver
        int mode;
        int left;
        int hold;
        mode       = 0;
        left       = 0;
        hold       = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                hold      = STALL_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_m_tready <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(1, 64);
                end
                left--;
                case (mode)
                    0, 1: i_m_tready <= 1'b1;
                    2: i_m_tready <= 1'($urandom_range(0, 1));
                    default: i_m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : main
        vcrr_pkg::t_item it;
        int              n;
        int              waited;
        bit              stalled;
        bit              paused;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        mismatch_cnt = 0;
        burst_left   = 0;
        stall_req    = 1'b0;
        slot_busy    = '0;
        rr_ptr       = '0;
        grant_on     = 1'b0;
        grant_ch     = '0;
        in_stop      = '0;
        for (int c = 0; c < vcrr_pkg::NUM_VC; c++)
            slot_msg[c] = '0;

        add_row(vcrr_pkg::ACT_SEND,      2'd0, 32'h0,        4'h0, 1'b1, '0);
        add_row(vcrr_pkg::ACT_ARBITRATE, 2'd0, 32'h0,        4'h0, 1'b1, '0);
        add_row(vcrr_pkg::ACT_STOP_RISE, 2'd0, 32'h0,        4'h0, 1'b1, '0);
        add_row(vcrr_pkg::ACT_ARRIVE,    2'd0, 32'h0,        4'h0, 1'b1, '0);
        add_row(vcrr_pkg::ACT_ARRIVE,    2'd3, 32'hFFFFFFFF, 4'hF, 1'b1, '0);
        add_row(vcrr_pkg::ACT_ARRIVE,    2'd1, 32'hA5A5A5A5, 4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_ARRIVE,    2'd2, 32'h5A5A5A5A, 4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_ARRIVE,    2'd0, 32'h12345678, 4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_ARBITRATE, 2'd0, 32'h0,        4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_SEND,      2'd0, 32'h0,        4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_ARBITRATE, 2'd0, 32'h0,        4'hF, 1'b0, '0);
        add_row(vcrr_pkg::ACT_ARBITRATE, 2'd0, 32'h0,        4'h2, 1'b0, '0);
        add_row(vcrr_pkg::ACT_STOP_RISE, 2'd1, 32'h0,        4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_STOP_RISE, 2'd2, 32'h0,        4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_SEND,      2'd0, 32'h0,        4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_ARBITRATE, 2'd0, 32'h0,        4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_SEND,      2'd0, 32'h0,        4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_ARBITRATE, 2'd0, 32'h0,        4'h8, 1'b0, '0);
        add_row(vcrr_pkg::ACT_SEND,      2'd0, 32'h0,        4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_ARBITRATE, 2'd0, 32'h0,        4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_SEND,      2'd0, 32'h0,        4'h0, 1'b0, '0);
        add_row(vcrr_pkg::ACT_ARBITRATE, 2'd0, 32'h0,        4'h0, 1'b0, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            offer(dir_rows[i]);

        n       = 0;
        stalled = 1'b0;
        paused  = 1'b0;
        while (n < RANDOM_ITEMS) begin
            if (!stalled && n >= 400) begin
                stalled   = 1'b1;
                stall_req = 1'b1;
            end
            if (!paused && n >= 900) begin
                paused = 1'b1;
                i_s_tvalid <= 1'b0;
                while (pending_q.size() != 0) @(negedge i_clk);
                burst_left = 0;
            end
            if ($urandom_range(0, 9) == 0) begin
                offer_item(rand_item(vcrr_pkg::t_action'($urandom_range(0, 3))));
                n++;
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    offer_item(rand_item(vcrr_pkg::ACT_ARRIVE));
                    n++;
                end
                it = rand_item(vcrr_pkg::ACT_ARBITRATE);
                if ($urandom_range(0, 1) == 0)
                    it.downstream_stop = '0;
                offer_item(it);
                n++;
                if ($urandom_range(0, 4) == 0) begin
                    it = rand_item(vcrr_pkg::ACT_STOP_RISE);
                    if (grant_on && $urandom_range(0, 3) != 0)
                        it.port = grant_ch;
                    offer_item(it);
                    n++;
                end
                if ($urandom_range(0, 6) != 0) begin
                    offer_item(rand_item(vcrr_pkg::ACT_SEND));
                    n++;
                end
            end
        end

        i_s_tvalid <= 1'b0;
        waited = 0;
        while (pending_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/vcrr_pkg.sv
hdl/vcrr_scan.sv
hdl/vcrr_state.sv
hdl/vc_round_robin_multiplexer.sv
dv/testbench.sv
